@@ hdl/ppue_pkg.sv @@
package ppue_pkg;

  localparam int POOL_SLOTS = 64;
  localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CNT_W = $clog2(POOL_SLOTS + 1);
  localparam int ENTRY_W = 32 + 32 + 16 + 16 + 24;
  localparam logic [62:0] RETIRE_RESET = 63'd8589934592000000;
  localparam logic [62:0] MAX63 = {63{1'b1}};
  localparam int MOVE_SHIFT = 22;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAWN,
    ST_RD,
    ST_WAIT,
    ST_MUL1,
    ST_MUL2,
    ST_MOVE,
    ST_DIFF,
    ST_SQ,
    ST_SUM,
    ST_CMP,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic spawn_wr;
    logic rd;
    logic mul1;
    logic mul2;
    logic move;
    logic diff;
    logic sq;
    logic sum;
    logic cmp;
    logic next_slot;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic have_free;
    logic last_slot;
    logic cur_active;
  } dp_sts_t;

endpackage

@@ hdl/particle_pool_update_engine.sv @@
// Particle pool update engine.
// Input: pulse start while busy is low with the in_ fields; in_cmd 0 spawns
// a particle into the lowest free slot, in_cmd 1 advances all active slots
// one frame and retires those at or beyond the distance limit.
// Result: one item per input, shown on out_ ports for one cycle with
// out_valid high. The receiver cannot stall; busy stays high until then.
// A tick walks the 64 slots one at a time through the slot memory, which
// has separate read and write ports, and shared multipliers: it skips
// inactive slots and takes each active one through rd, wait, mul1, mul2,
// move, diff, sq, sum and cmp. busy falls with out_valid, so the next
// item can be accepted at the edge that takes the result.
// Configuration: APB port, register 0 (retire_distance_sq, 63 bits) at
// address 0, 64-bit data; write only while busy is low.
// Reset (rst_n low, synchronous): all slots inactive, limit back to its
// default; slot memory contents are left as they were.
module particle_pool_update_engine
  import ppue_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_cmd,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic [23:0]        in_speed,
  input  logic signed [31:0] in_ref_x,
  input  logic signed [31:0] in_ref_y,
  input  logic [15:0]        in_frame_dt,
  output logic               out_valid,
  output logic               out_accepted,
  output logic [5:0]         out_slot_index,
  output logic [6:0]         out_active_count,
  output logic [6:0]         out_retired_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  logic [62:0] limit_r;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  assign pready = 1'b1;
  assign prdata = paddr ? 64'd0 : {1'b0, limit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= RETIRE_RESET;
    end else if (psel && penable && pwrite && !paddr) begin
      limit_r <= pwdata[62:0];
    end
  end

  ppue_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  ppue_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .limit             (limit_r),
    .in_cmd            (in_cmd),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_dir_x          (in_dir_x),
    .in_dir_y          (in_dir_y),
    .in_speed          (in_speed),
    .in_ref_x          (in_ref_x),
    .in_ref_y          (in_ref_y),
    .in_frame_dt       (in_frame_dt),
    .out_valid         (out_valid),
    .out_accepted      (out_accepted),
    .out_slot_index    (out_slot_index),
    .out_active_count  (out_active_count),
    .out_retired_count (out_retired_count)
  );

endmodule

@@ hdl/ppue_ram.sv @@
module ppue_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/ppue_ctrl.sv @@
module ppue_ctrl
  import ppue_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  dp_sts_t sts,
  output logic    busy,
  output dp_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = ST_SPAWN;
        end
      end
      ST_SPAWN: begin
        if (sts.is_tick) begin
          state_nxt = ST_RD;
        end else begin
          cmd.spawn_wr = sts.have_free;
          state_nxt = ST_DONE;
        end
      end
      ST_RD: begin
        if (sts.cur_active) begin
          cmd.rd = 1'b1;
          state_nxt = ST_WAIT;
        end else if (sts.last_slot) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.next_slot = 1'b1;
        end
      end
      ST_WAIT: state_nxt = ST_MUL1;
      ST_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = ST_MOVE;
      end
      ST_MOVE: begin
        cmd.move = 1'b1;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff = 1'b1;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
        if (sts.last_slot) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.next_slot = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_DONE: begin
        cmd.emit = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/ppue_dp.sv @@
module ppue_dp
  import ppue_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic [62:0]       limit,
  input  logic              in_cmd,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic [23:0]       in_speed,
  input  logic signed [31:0] in_ref_x,
  input  logic signed [31:0] in_ref_y,
  input  logic [15:0]       in_frame_dt,
  output logic              out_valid,
  output logic              out_accepted,
  output logic [5:0]        out_slot_index,
  output logic [6:0]        out_active_count,
  output logic [6:0]        out_retired_count
);

  logic [POOL_SLOTS-1:0] act_r;
  logic [CNT_W-1:0]      act_cnt_r, ret_cnt_r;
  logic [SLOT_W-1:0]     idx_r, free_idx;
  logic                  have_free;
  logic                  tick_r, acc_r;
  logic signed [31:0]    rx_r, ry_r;
  logic [15:0]           dt_r;
  logic [ENTRY_W-1:0]    new_r;
  logic [ENTRY_W-1:0]    wdata, rdata;
  logic                  we;
  logic [SLOT_W-1:0]     waddr;
  logic signed [31:0]    px, py, npx_r, npy_r;
  logic signed [15:0]    dx, dy;
  logic [23:0]           spd;
  logic [39:0]           step_r;
  logic signed [56:0]    mx_r, my_r;
  logic signed [32:0]    ddx_r, ddy_r;
  logic [63:0]           sqx_r, sqy_r;
  logic [62:0]           sum_r;
  logic signed [34:0]    tx, ty;
  logic [32:0]           ax, ay;
  logic [64:0]           s65;

  always_comb begin
    have_free = 1'b0;
    free_idx = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        have_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign {px, py, dx, dy, spd} = rdata;
  assign we = cmd.spawn_wr | cmd.cmp;
  assign waddr = cmd.spawn_wr ? free_idx : idx_r;
  assign wdata = cmd.spawn_wr ? new_r : {npx_r, npy_r, dx, dy, spd};

  ppue_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign sts.is_tick = tick_r;
  assign sts.have_free = have_free;
  assign sts.last_slot = (idx_r == SLOT_W'(POOL_SLOTS - 1));
  assign sts.cur_active = act_r[idx_r];

  assign tx = $signed({{3{px[31]}}, px}) + 35'(mx_r >>> MOVE_SHIFT);
  assign ty = $signed({{3{py[31]}}, py}) + 35'(my_r >>> MOVE_SHIFT);
  assign ax = ddx_r[32] ? 33'(-ddx_r) : 33'(ddx_r);
  assign ay = ddy_r[32] ? 33'(-ddy_r) : 33'(ddy_r);
  assign s65 = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      act_cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
      if (cmd.spawn_wr) begin
        act_r[free_idx] <= 1'b1;
        act_cnt_r <= act_cnt_r + 1'b1;
      end
      if (cmd.cmp && sum_r >= limit) begin
        act_r[idx_r] <= 1'b0;
        act_cnt_r <= act_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tick_r <= in_cmd;
      rx_r <= in_ref_x;
      ry_r <= in_ref_y;
      dt_r <= in_frame_dt;
      new_r <= {in_start_x, in_start_y, in_dir_x, in_dir_y, in_speed};
      idx_r <= '0;
      ret_cnt_r <= '0;
      acc_r <= in_cmd;
    end
    if (cmd.spawn_wr) begin
      acc_r <= 1'b1;
      idx_r <= free_idx;
    end
    if (cmd.next_slot) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.mul1) begin
      step_r <= spd * dt_r;
    end
    if (cmd.mul2) begin
      mx_r <= dx * $signed({1'b0, step_r});
      my_r <= dy * $signed({1'b0, step_r});
    end
    if (cmd.move) begin
      npx_r <= (tx > 35'sh7FFFFFFF) ? 32'sh7FFFFFFF :
               (tx < -35'sh80000000) ? 32'sh80000000 : tx[31:0];
      npy_r <= (ty > 35'sh7FFFFFFF) ? 32'sh7FFFFFFF :
               (ty < -35'sh80000000) ? 32'sh80000000 : ty[31:0];
    end
    if (cmd.diff) begin
      ddx_r <= 33'(npx_r) - 33'(rx_r);
      ddy_r <= 33'(npy_r) - 33'(ry_r);
    end
    if (cmd.sq) begin
      sqx_r <= 64'(ax * ax);
      sqy_r <= 64'(ay * ay);
    end
    if (cmd.sum) begin
      sum_r <= (s65[64:63] != 2'b00) ? MAX63 : s65[62:0];
    end
    if (cmd.cmp && sum_r >= limit) begin
      ret_cnt_r <= ret_cnt_r + 1'b1;
    end
    if (cmd.emit) begin
      out_accepted <= acc_r;
      out_slot_index <= (tick_r || !acc_r) ? 6'd0 : 6'(idx_r);
      out_active_count <= 7'(act_cnt_r);
      out_retired_count <= tick_r ? 7'(ret_cnt_r) : 7'd0;
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb
  import ppue_pkg::*;
();

  localparam int CYCLE_LIMIT = 3000000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 200;
  localparam logic CMD_SPAWN = 1'b0;
  localparam logic CMD_TICK = 1'b1;
  localparam logic ADDR_RETIRE = 1'b0;

  typedef struct {
    logic              cmd;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [23:0]        speed;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic [15:0]        frame_dt;
  } pool_cmd_t;

  typedef struct packed {
    logic       accepted;
    logic [5:0] slot_index;
    logic [6:0] active_count;
    logic [6:0] retired_count;
  } pool_resp_t;

  class pool_scoreboard;
    bit                 live[64];
    logic signed [31:0] px[64];
    logic signed [31:0] py[64];
    logic signed [15:0] vx[64];
    logic signed [15:0] vy[64];
    logic [23:0]        spd[64];
    logic [62:0]        limit_sq;
    pool_resp_t         pending[$];
    int                 mismatches;

    function void clear();
      foreach (live[i]) live[i] = 0;
      limit_sq = RETIRE_RESET;
      pending.delete();
      mismatches = 0;
    endfunction

    function logic signed [31:0] advance(logic signed [31:0] pos, logic signed [15:0] dir,
                                         logic [39:0] step);
      longint p;
      longint n;
      p = longint'(dir) * longint'({24'd0, step});
      n = longint'(pos) + (p >>> MOVE_SHIFT);
      if (n > 64'sd2147483647) return 32'sh7fffffff;
      if (n < -64'sd2147483648) return 32'sh80000000;
      return n[31:0];
    endfunction

    function void note_item(pool_cmd_t c);
      pool_resp_t r;
      int n;
      logic [39:0] step;
      longint dx;
      longint dy;
      logic [65:0] dsum;
      logic [62:0] dist_sq;
      r = '{1'b0, 6'd0, 7'd0, 7'd0};
      if (c.cmd == CMD_SPAWN) begin
        for (int i = 0; i < 64; i++) begin
          if (!live[i]) begin
            live[i] = 1;
            px[i] = c.start_x;
            py[i] = c.start_y;
            vx[i] = c.dir_x;
            vy[i] = c.dir_y;
            spd[i] = c.speed;
            r.accepted = 1'b1;
            r.slot_index = 6'(i);
            break;
          end
        end
      end else begin
        r.accepted = 1'b1;
        for (int i = 0; i < 64; i++) begin
          if (!live[i]) continue;
          step = spd[i] * c.frame_dt;
          px[i] = advance(px[i], vx[i], step);
          py[i] = advance(py[i], vy[i], step);
          dx = longint'(px[i]) - longint'(c.ref_x);
          dy = longint'(py[i]) - longint'(c.ref_y);
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          dsum = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy);
          dist_sq = (dsum > 66'(MAX63)) ? MAX63 : dsum[62:0];
          if (dist_sq >= limit_sq) begin
            live[i] = 0;
            r.retired_count++;
          end
        end
      end
      n = 0;
      foreach (live[i]) n += live[i];
      r.active_count = 7'(n);
      pending.push_back(r);
    endfunction

    function void check_result(pool_resp_t got);
      pool_resp_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: acc=%0d slot=%0d act=%0d ret=%0d",
                                       got.accepted, got.slot_index, got.active_count,
                                       got.retired_count);
        return;
      end
      want = pending.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected acc=%0d slot=%0d act=%0d ret=%0d, got %0d %0d %0d %0d",
                   want.accepted, want.slot_index, want.active_count, want.retired_count,
                   got.accepted, got.slot_index, got.active_count, got.retired_count);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  pool_cmd_t drv;
  logic out_valid;
  logic out_accepted;
  logic [5:0] out_slot_index;
  logic [6:0] out_active_count;
  logic [6:0] out_retired_count;
  logic psel;
  logic penable;
  logic pwrite;
  logic paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;
  int cycles;
  pool_scoreboard sb;

  particle_pool_update_engine dut (
    .clk, .rst_n, .start, .busy,
    .in_cmd(drv.cmd), .in_start_x(drv.start_x), .in_start_y(drv.start_y),
    .in_dir_x(drv.dir_x), .in_dir_y(drv.dir_y), .in_speed(drv.speed),
    .in_ref_x(drv.ref_x), .in_ref_y(drv.ref_y), .in_frame_dt(drv.frame_dt),
    .out_valid, .out_accepted, .out_slot_index, .out_active_count, .out_retired_count,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("particle_pool_update_engine test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result('{out_accepted, out_slot_index, out_active_count, out_retired_count});
  end

  task automatic send_item(pool_cmd_t c);
    drv <= c;
    start <= 1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_item(c);
  endtask

  task automatic pause(int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [63:0] v);
    psel <= 1;
    pwrite <= 1;
    paddr <= ADDR_RETIRE;
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.limit_sq = v[62:0];
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic pool_cmd_t rand_item(int spawn_pct);
    pool_cmd_t c;
    c.cmd = ($urandom_range(0, 99) < spawn_pct) ? CMD_SPAWN : CMD_TICK;
    c.start_x = pick32();
    c.start_y = pick32();
    c.ref_x = pick32();
    c.ref_y = pick32();
    c.dir_x = 16'($urandom);
    c.dir_y = 16'($urandom);
    c.speed = ($urandom_range(0, 7) == 0) ? 24'hffffff : 24'($urandom);
    case ($urandom_range(0, 5))
      0: c.frame_dt = 16'hffff;
      1: c.frame_dt = 16'd0;
      2: c.frame_dt = 16'($urandom);
      default: c.frame_dt = 16'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  function automatic pool_cmd_t make_spawn(logic [31:0] x, logic [31:0] y, logic [15:0] vx,
                                           logic [15:0] vy, logic [23:0] s);
    pool_cmd_t c;
    c = rand_item(100);
    c.start_x = x;
    c.start_y = y;
    c.dir_x = vx;
    c.dir_y = vy;
    c.speed = s;
    return c;
  endfunction

  function automatic pool_cmd_t make_tick(logic [31:0] rx, logic [31:0] ry, logic [15:0] dt);
    pool_cmd_t c;
    c = rand_item(0);
    c.ref_x = rx;
    c.ref_y = ry;
    c.frame_dt = dt;
    return c;
  endfunction

  initial begin
    logic [63:0] lim;
    int spawn_pct;
    cycles = 0;
    sb = new();
    sb.clear();
    rst_n = 0;
    start = 0;
    drv = '{default: '0};
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = ADDR_RETIRE;
    pwdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_item(make_spawn(32'h7fffffff, 32'h80000000, 16'h7fff, 16'h8000, 24'hffffff));
    send_item(make_spawn(32'h80000000, 32'h7fffffff, 16'h8000, 16'h7fff, 24'h000000));
    send_item(make_spawn(32'h0, 32'h0, 16'h4000, 16'hc000, 24'h000100));
    send_item(make_spawn(32'hffffffff, 32'h1, 16'h0, 16'h0, 24'hffffff));
    send_item(make_tick(32'h0, 32'h0, 16'h0));
    send_item(make_tick(32'h80000000, 32'h7fffffff, 16'hffff));
    send_item(make_tick(32'h7fffffff, 32'h80000000, 16'h0001));
    drain();
    write_limit(64'hffffffffffffffff);
    for (int i = 0; i < 66; i++)
      send_item(make_spawn(pick32(), pick32(), 16'($urandom), 16'($urandom),
                           24'($urandom)));
    send_item(make_tick(32'h0, 32'h0, 16'hffff));
    drain();
    write_limit(64'd0);
    send_item(make_tick(32'h0, 32'h0, 16'h0));
    send_item(make_spawn(32'h0, 32'h0, 16'h0, 16'h0, 24'h0));
    send_item(make_tick(32'h0, 32'h0, 16'h0));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: lim = 64'h7fffffffffffffff;
        1: lim = {$urandom, $urandom};
        2: lim = 64'(RETIRE_RESET);
        3: lim = 64'd0;
        4: lim = {32'd0, $urandom} << $urandom_range(0, 31);
        default: lim = {$urandom, $urandom};
      endcase
      write_limit(lim);
      spawn_pct = $urandom_range(40, 90);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_item(rand_item(spawn_pct));
        if (p == 1 && i == 100) drain();
        else if (p < PHASES - 1 && $urandom_range(0, 3) == 0) pause($urandom_range(1, 12));
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("particle_pool_update_engine test passed");
    end else begin
      $display("particle_pool_update_engine test failed");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hdl/ppue_pkg.sv
hdl/ppue_ram.sv
hdl/ppue_ctrl.sv
hdl/ppue_dp.sv
hdl/particle_pool_update_engine.sv
test/tb.sv
